// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk while rstn is high
`define RFD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check that cond never holds while rstn is high
`define RFD_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define RFD_ASSERT(label, clk, rstn, prop)
`define RFD_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// File: hw/rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Types and constants of the remote frame decoder.
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int HEAD_LEN    = 6;
    localparam int COUNT_W     = 5;
    localparam int CH_W        = 11;
    localparam int SW_W        = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
    localparam logic [CH_W-1:0]    CH_MIN_RST  = 11'd364;
    localparam logic [CH_W-1:0]    CH_MAX_RST  = 11'd1684;
    localparam logic [SW_W-1:0]    SW_LOWEST   = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_MIN = 2'd0,
        REG_CHANNEL_MAX = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic            frame_ok;
        logic [CH_W-1:0] stick_0;
        logic [CH_W-1:0] stick_1;
        logic [CH_W-1:0] stick_2;
        logic [CH_W-1:0] stick_3;
        logic [SW_W-1:0] left_switch;
        logic [SW_W-1:0] right_switch;
    } out_item_t;

    // One closed frame: final byte count and its first bytes
    typedef struct packed {
        logic [COUNT_W-1:0]           count;
        logic [HEAD_LEN-1:0][7:0]     head;
    } frame_t;

    // Handshake between the capture stage and the output stage
    typedef struct packed {
        logic valid;
        logic ready;
    } stage_ctl_t;

endpackage

// File: hw/rtl/rfd_capture.sv
// ----------------------------------------------------------------------------
// rfd_capture
// Counts frame bytes, keeps the head bytes and registers each closed frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfd_capture (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  rfd_pkg::in_item_t    s_payload,
    input  logic                 frame_take,
    output rfd_pkg::stage_ctl_t  ctl,
    output rfd_pkg::frame_t      frame
);

    localparam int CW = rfd_pkg::COUNT_W;
    localparam int HL = rfd_pkg::HEAD_LEN;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       count_inc;
    logic [HL-1:0][7:0]  head_reg;
    logic [HL-1:0][7:0]  head_merged;
    logic                frame_valid_reg;
    logic                frame_valid_next;
    rfd_pkg::frame_t     frame_reg;
    logic                in_fire;

    assign ctl.ready = !frame_valid_reg || frame_take;
    assign ctl.valid = frame_valid_reg;
    assign frame     = frame_reg;
    assign in_fire   = s_valid && ctl.ready;

    // Saturating count including the byte now arriving
    assign count_inc = (count_reg < rfd_pkg::COUNT_MAX) ? count_reg + CW'(1) : count_reg;

    always_comb begin
        for (int i = 0; i < HL; i++) begin
            head_merged[i] = (count_reg == CW'(i)) ? s_payload.rx_byte : head_reg[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (in_fire) begin
            count_next = s_payload.end_of_frame ? '0 : count_inc;
        end
    end

    always_comb begin
        frame_valid_next = frame_valid_reg;
        if (in_fire && s_payload.end_of_frame) begin
            frame_valid_next = 1'b1;
        end else if (frame_take) begin
            frame_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            frame_valid_reg <= 1'b0;
        end else begin
            count_reg       <= count_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            head_reg <= head_merged;
        end
        if (in_fire && s_payload.end_of_frame) begin
            frame_reg.count <= count_inc;
            frame_reg.head  <= head_merged;
        end
    end

    `RFD_ASSERT(a_count_clears, aclk, aresetn,
        (in_fire && s_payload.end_of_frame) |=> (count_reg == '0))
    `RFD_ASSERT(a_count_moves, aclk, aresetn,
        (in_fire && !s_payload.end_of_frame) |=> (count_reg != '0))

endmodule

// File: hw/rtl/rfd_check.sv
// ----------------------------------------------------------------------------
// rfd_check
// Unpacks the stick and switch fields of a closed frame and validates them.
// ----------------------------------------------------------------------------
module rfd_check (
    input  rfd_pkg::frame_t                 frame,
    input  logic [rfd_pkg::CH_W-1:0]        channel_min,
    input  logic [rfd_pkg::CH_W-1:0]        channel_max,
    output rfd_pkg::out_item_t              result
);

    localparam int CHW = rfd_pkg::CH_W;
    localparam int SWW = rfd_pkg::SW_W;

    logic [3:0][CHW-1:0] stick;
    logic [3:0]          in_range;
    logic [SWW-1:0]      sw_left;
    logic [SWW-1:0]      sw_right;
    logic                len_ok;
    logic                ok;

    // Little-endian packed 11-bit channels across the first six bytes
    assign stick[0] = {frame.head[1][2:0], frame.head[0]};
    assign stick[1] = {frame.head[2][5:0], frame.head[1][7:3]};
    assign stick[2] = {frame.head[4][0], frame.head[3], frame.head[2][7:6]};
    assign stick[3] = {frame.head[5][3:0], frame.head[4][7:1]};

    assign sw_left  = frame.head[5][7:6];
    assign sw_right = frame.head[5][5:4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_range[i] = (stick[i] >= channel_min) && (stick[i] <= channel_max);
        end
    end

    assign len_ok = (frame.count == rfd_pkg::COUNT_W'(rfd_pkg::FRAME_BYTES));
    assign ok     = len_ok && (&in_range)
                 && (sw_left >= rfd_pkg::SW_LOWEST) && (sw_right >= rfd_pkg::SW_LOWEST);

    // Zero every data field of a rejected frame
    always_comb begin
        result.frame_ok     = ok;
        result.stick_0      = ok ? stick[0] : '0;
        result.stick_1      = ok ? stick[1] : '0;
        result.stick_2      = ok ? stick[2] : '0;
        result.stick_3      = ok ? stick[3] : '0;
        result.left_switch  = ok ? sw_left  : '0;
        result.right_switch = ok ? sw_right : '0;
    end

endmodule

// File: hw/rtl/remote_frame_decoder.sv
// ----------------------------------------------------------------------------
// remote_frame_decoder
// Decodes radio remote receiver frames arriving one byte per transfer.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload             Meaning
// s_        in         rfd_pkg::in_item_t  frame byte plus end-of-frame flag
// m_        out        rfd_pkg::out_item_t one result per closed frame
// cfg_      in         cfg_wdata, 11 bits  channel_min (0), channel_max (1)
//
// One byte per cycle is accepted while s_ready is high. The transfer of a
// frame's final byte loads the frame register; the checked result then
// moves into the output register, and raises m_valid, once that register
// is empty or being drained. Reset clears the byte count and both valid
// flags and loads the default channel limits. A stalled result holds in
// the output register while the frame register behind it can still take
// one more frame; only when both are full does s_ready drop.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module remote_frame_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rfd_pkg::in_item_t             s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rfd_pkg::out_item_t            m_payload,
    input  logic                          cfg_we,
    input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfd_pkg::CH_W-1:0]      cfg_wdata
);

    logic [rfd_pkg::CH_W-1:0] channel_min_reg;
    logic [rfd_pkg::CH_W-1:0] channel_max_reg;
    rfd_pkg::stage_ctl_t      cap_ctl;
    rfd_pkg::frame_t          frame;
    rfd_pkg::out_item_t       result;
    rfd_pkg::out_item_t       m_payload_reg;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic                     out_adv;

    // Advance the output register when it is empty or being drained
    assign out_adv = !m_valid_reg || m_ready;

    rfd_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_payload  (s_payload),
        .frame_take (out_adv),
        .ctl        (cap_ctl),
        .frame      (frame)
    );

    rfd_check u_check (
        .frame       (frame),
        .channel_min (channel_min_reg),
        .channel_max (channel_max_reg),
        .result      (result)
    );

    assign s_ready   = cap_ctl.ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Configuration writes; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_min_reg <= rfd_pkg::CH_MIN_RST;
            channel_max_reg <= rfd_pkg::CH_MAX_RST;
        end else if (cfg_we) begin
            unique case (rfd_pkg::reg_index_t'(cfg_index))
                rfd_pkg::REG_CHANNEL_MIN: channel_min_reg <= cfg_wdata;
                rfd_pkg::REG_CHANNEL_MAX: channel_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_adv) begin
            m_valid_next = cap_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the checked frame into the output register
    always_ff @(posedge aclk) begin
        if (out_adv && cap_ctl.valid) begin
            m_payload_reg <= result;
        end
    end

    `RFD_ASSERT(a_backpressure, aclk, aresetn,
        (cap_ctl.valid && m_valid_reg && !m_ready) |-> !s_ready)
    `RFD_ASSERT(a_frame_moves, aclk, aresetn,
        (cap_ctl.valid && out_adv) |=> m_valid_reg)
    `RFD_ASSERT_NEVER(a_reject_zero, aclk, aresetn,
        m_valid_reg && !m_payload_reg.frame_ok
        && ((m_payload_reg.stick_0 != '0) || (m_payload_reg.stick_1 != '0)
            || (m_payload_reg.stick_2 != '0) || (m_payload_reg.stick_3 != '0)
            || (m_payload_reg.left_switch != '0) || (m_payload_reg.right_switch != '0)))

endmodule

// File: tb/rfd_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_decode_checker
// Watches the byte, result and register-write ports of the remote frame
// decoder, decodes every closed frame on its own and compares each result
// transfer, field by field, against the oldest decoded frame still due.
// ----------------------------------------------------------------------------
module rfd_decode_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  rfd_pkg::in_item_t             s_payload,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  rfd_pkg::out_item_t            m_payload,
    input  logic                          cfg_we,
    input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfd_pkg::CH_W-1:0]      cfg_wdata,
    output int                            fail_count,
    output int                            frames_due
);
    import rfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [COUNT_W-1:0]       byte_cnt;
    logic [HEAD_LEN-1:0][7:0] head_buf;
    logic [CH_W-1:0]          lim_lo;
    logic [CH_W-1:0]          lim_hi;
    out_item_t                decoded_frames[$];

    // Unpack the four sticks and two switches, then apply length, range and
    // switch checks; a rejected frame reads all zero.
    function automatic out_item_t decode_frame(input logic [HEAD_LEN-1:0][7:0] hb,
                                               input logic [COUNT_W-1:0] cnt,
                                               input logic [CH_W-1:0] lo,
                                               input logic [CH_W-1:0] hi);
        logic [CH_W-1:0] stick [4];
        logic [SW_W-1:0] left;
        logic [SW_W-1:0] right;
        logic            ok;
        out_item_t       res;
        stick[0] = {hb[1][2:0], hb[0]};
        stick[1] = {hb[2][5:0], hb[1][7:3]};
        stick[2] = {hb[4][0], hb[3], hb[2][7:6]};
        stick[3] = {hb[5][3:0], hb[4][7:1]};
        left     = hb[5][7:6];
        right    = hb[5][5:4];
        ok = (cnt == FRAME_BYTES) && (left >= SW_LOWEST) && (right >= SW_LOWEST);
        foreach (stick[i]) begin
            if (stick[i] < lo || stick[i] > hi)
                ok = 1'b0;
        end
        res = '0;
        if (ok) begin
            res.frame_ok     = 1'b1;
            res.stick_0      = stick[0];
            res.stick_1      = stick[1];
            res.stick_2      = stick[2];
            res.stick_3      = stick[3];
            res.left_switch  = left;
            res.right_switch = right;
        end
        return res;
    endfunction

    task automatic log_failure(input string what, input out_item_t want,
                               input out_item_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t %s", $time, what);
            $display("  expected ok=%0d sticks=%0d/%0d/%0d/%0d sw=%0d/%0d",
                     want.frame_ok, want.stick_0, want.stick_1, want.stick_2,
                     want.stick_3, want.left_switch, want.right_switch);
            $display("  actual   ok=%0d sticks=%0d/%0d/%0d/%0d sw=%0d/%0d",
                     got.frame_ok, got.stick_0, got.stick_1, got.stick_2,
                     got.stick_3, got.left_switch, got.right_switch);
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            byte_cnt   = '0;
            head_buf   = '0;
            lim_lo     = CH_MIN_RST;
            lim_hi     = CH_MAX_RST;
            fail_count = 0;
            decoded_frames.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHANNEL_MIN: lim_lo = cfg_wdata;
                    REG_CHANNEL_MAX: lim_hi = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (byte_cnt < HEAD_LEN)
                    head_buf[byte_cnt[2:0]] = s_payload.rx_byte;
                if (byte_cnt != COUNT_MAX)
                    byte_cnt++;
                if (s_payload.end_of_frame) begin
                    decoded_frames.push_back(decode_frame(head_buf, byte_cnt, lim_lo, lim_hi));
                    byte_cnt = '0;
                end
            end
            if (m_valid && m_ready) begin
                if (decoded_frames.size() == 0) begin
                    log_failure("result with no frame due", '0, m_payload);
                end else begin
                    want = decoded_frames.pop_front();
                    if (m_payload.frame_ok     !== want.frame_ok     ||
                        m_payload.stick_0      !== want.stick_0      ||
                        m_payload.stick_1      !== want.stick_1      ||
                        m_payload.stick_2      !== want.stick_2      ||
                        m_payload.stick_3      !== want.stick_3      ||
                        m_payload.left_switch  !== want.left_switch  ||
                        m_payload.right_switch !== want.right_switch)
                        log_failure("result mismatch", want, m_payload);
                end
            end
        end
        frames_due = decoded_frames.size();
    end

endmodule

// File: tb/tb_remote_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_remote_frame_decoder
// Feeds the decoder directed and random byte streams, mostly well-formed
// frames with random sticks and switches plus noise frames of random length,
// across several channel limit settings and idle patterns on both sides.
// A side checker decodes each frame independently and flags mismatches.
// ----------------------------------------------------------------------------
module tb_remote_frame_decoder;
    import rfd_pkg::*;

    localparam int SEGMENTS     = 7;
    localparam int SEG_BYTES    = 250;
    localparam int MAX_FRAME    = 40;
    localparam int DRAIN_CYCLES = 6;
    localparam int LIMIT_NS     = 2_000_000;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_STICK,
        FLAW_SWITCH,
        FLAW_LENGTH
    } flaw_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_payload;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_payload;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CH_W-1:0]      cfg_wdata;

    int         send_idle_pct;
    int         recv_idle_pct;
    int         fail_count;
    int         frames_due;
    int         sent_bytes;
    int         cur_lo;
    int         cur_hi;
    logic [7:0] frame_buf [MAX_FRAME];

    remote_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rfd_decode_checker decode_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .frames_due (frames_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case a transfer or a result never shows up
    initial begin
        #LIMIT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: drop ready at random, at the rate of the current phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Present one byte and hold it until the transfer; leave valid high so a
    // back-to-back byte needs no second assignment in the same step.
    task automatic send_byte(input logic [7:0] value, input logic closing);
        int gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{rx_byte: value, end_of_frame: closing};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        sent_bytes++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_byte(frame_buf[i], i == len - 1);
    endtask

    // Hold the sender off until every due result is out, then let the
    // pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (frames_due != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write both limits, then poke the two unused indexes with junk
    task automatic set_limits(input int lo, input int hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHANNEL_MIN;
        cfg_wdata <= CH_W'(lo);
        @(negedge aclk);
        cfg_index <= REG_CHANNEL_MAX;
        cfg_wdata <= CH_W'(hi);
        @(negedge aclk);
        cfg_index <= REG_SPARE_2;
        cfg_wdata <= CH_W'($urandom_range(2047, 0));
        @(negedge aclk);
        cfg_index <= REG_SPARE_3;
        cfg_wdata <= CH_W'($urandom_range(2047, 0));
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // Pack sticks and switches into the first six bytes, little-endian
    function automatic void pack_head(input logic [CH_W-1:0] c0, input logic [CH_W-1:0] c1,
                                      input logic [CH_W-1:0] c2, input logic [CH_W-1:0] c3,
                                      input logic [SW_W-1:0] left,
                                      input logic [SW_W-1:0] right);
        frame_buf[0] = c0[7:0];
        frame_buf[1] = {c1[4:0], c0[10:8]};
        frame_buf[2] = {c2[1:0], c1[10:5]};
        frame_buf[3] = c2[9:2];
        frame_buf[4] = {c3[6:0], c2[10]};
        frame_buf[5] = {left, right, c3[10:7]};
    endfunction

    // Pick a stick value inside the limits (often right on an edge), or
    // outside them, where the limits leave room, when fit is low.
    function automatic logic [CH_W-1:0] pick_stick(input int lo, input int hi, input bit fit);
        int r;
        r = $urandom_range(3, 0);
        if (fit && lo <= hi) begin
            if (r == 0)
                return CH_W'(lo);
            if (r == 1)
                return CH_W'(hi);
            return CH_W'($urandom_range(hi, lo));
        end
        if (!fit) begin
            if (lo > 0 && (hi >= 2047 || r[0]))
                return (r == 0) ? CH_W'(lo - 1) : CH_W'($urandom_range(lo - 1, 0));
            if (hi < 2047)
                return (r == 1) ? CH_W'(hi + 1) : CH_W'($urandom_range(2047, hi + 1));
        end
        return CH_W'($urandom_range(2047, 0));
    endfunction

    initial begin
        int              seg_start;
        int              len;
        int              kind;
        int              bad_k;
        int              lim_a;
        int              lim_b;
        flaw_t           flaw;
        logic [CH_W-1:0] st [4];
        logic [SW_W-1:0] sw_l;
        logic [SW_W-1:0] sw_r;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_CHANNEL_MIN;
        cfg_wdata     = '0;
        send_idle_pct = 23;
        recv_idle_pct = 52;
        sent_bytes    = 0;
        cur_lo        = CH_MIN_RST;
        cur_hi        = CH_MAX_RST;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: a full frame at the reset limits with every stick on an
        // edge and the switches at their extremes; the tail alternates all
        // zeros and all ones. It also fills every head byte before any short
        // frame can read them.
        pack_head(CH_MIN_RST, CH_MAX_RST, CH_MIN_RST, CH_MAX_RST, 2'd3, SW_LOWEST);
        for (int i = HEAD_LEN; i < FRAME_BYTES; i++)
            frame_buf[i] = (i % 2) ? 8'hff : 8'h00;
        send_frame(FRAME_BYTES);
        // Single-byte frame: rejected on length, closes right away
        frame_buf[0] = 8'hff;
        send_frame(1);
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // Sender idles lightly first, then heavily, then neither side idles
            if (seg < 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 52;
            end else if (seg < 5) begin
                send_idle_pct = 52;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Sweep the limits: full span, both pinned extremes, inverted,
            // a random window, back to reset values, full span again.
            lim_a = $urandom_range(2047, 0);
            lim_b = $urandom_range(2047, 0);
            case (seg)
                0: set_limits(0, 2047);
                1: set_limits(0, 0);
                2: set_limits(2047, 2047);
                3: set_limits(CH_MAX_RST, CH_MIN_RST);
                4: set_limits((lim_a < lim_b) ? lim_a : lim_b,
                              (lim_a < lim_b) ? lim_b : lim_a);
                5: set_limits(CH_MIN_RST, CH_MAX_RST);
                default: set_limits(0, 2047);
            endcase

            seg_start = sent_bytes;
            while (sent_bytes - seg_start < SEG_BYTES) begin
                foreach (frame_buf[i])
                    frame_buf[i] = 8'($urandom_range(255, 0));
                kind = $urandom_range(99, 0);
                if (kind < 70) begin
                    // Well-formed frame, sometimes with one defect planted
                    len  = FRAME_BYTES;
                    flaw = (kind < 20) ? flaw_t'($urandom_range(3, 1)) : FLAW_NONE;
                    bad_k = $urandom_range(3, 0);
                    foreach (st[k])
                        st[k] = pick_stick(cur_lo, cur_hi, !(flaw == FLAW_STICK && k == bad_k));
                    sw_l = SW_W'($urandom_range(3, 1));
                    sw_r = SW_W'($urandom_range(3, 1));
                    if (flaw == FLAW_SWITCH) begin
                        if (bad_k[0])
                            sw_l = '0;
                        else
                            sw_r = '0;
                    end
                    if (flaw == FLAW_LENGTH)
                        len = bad_k[0] ? FRAME_BYTES - 1 : FRAME_BYTES + 1;
                    pack_head(st[0], st[1], st[2], st[3], sw_l, sw_r);
                end else begin
                    // Noise: random bytes, any length up to past saturation
                    len = $urandom_range(MAX_FRAME, 1);
                end
                send_frame(len);
                // Now and then hold off until the decoder has caught up
                if ($urandom_range(99, 0) < 3)
                    drain();
            end
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
